/* hw/rtl/assert_macros.svh */
// assertion macros shared by the calibrator rtl
// expects clk_i in the scope of every use, and rst_ni in the scope of every JAC_ASSERT
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define JAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define JAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/jac_pkg.sv */
// types and constants of the joystick axis calibrator
// no dependencies
`timescale 1ns / 1ps

package jac_pkg;

  localparam int unsigned MAG_W     = 12;
  localparam int unsigned CAL_W     = 36;
  localparam int unsigned DZ_W      = 12;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CAL_W-1:0] CAL_RESET = 36'h400400800;
  localparam logic [DZ_W-1:0]  DZ_RESET  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_X_CAL  = 3'd0,
    REG_LEFT_Y_CAL  = 3'd1,
    REG_RIGHT_X_CAL = 3'd2,
    REG_RIGHT_Y_CAL = 3'd3,
    REG_LEFT_DZ     = 3'd4,
    REG_RIGHT_DZ    = 3'd5
  } jac_reg_e;

  typedef struct packed {
    logic       side;
    logic [7:0] low_byte;
    logic [7:0] mid_byte;
    logic [7:0] high_byte;
  } jac_in_t;

  typedef struct packed {
    logic                    side_out;
    logic signed [OUT_W-1:0] x_value;
    logic signed [OUT_W-1:0] y_value;
  } jac_out_t;

  typedef struct packed {
    logic [CAL_W-1:0] left_x_cal;
    logic [CAL_W-1:0] left_y_cal;
    logic [CAL_W-1:0] right_x_cal;
    logic [CAL_W-1:0] right_y_cal;
    logic [DZ_W-1:0]  left_dz;
    logic [DZ_W-1:0]  right_dz;
  } jac_cfg_t;

  typedef struct packed {
    logic             neg;
    logic             zero;
    logic             sat;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] span;
  } jac_axis_t;

  typedef struct packed {
    logic      side;
    jac_axis_t x;
    jac_axis_t y;
  } jac_prep_t;

endpackage

/* hw/rtl/jac_stream_if.sv */
// valid/ready stream channel carrying one word of type T
// no dependencies
`timescale 1ns / 1ps

interface jac_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/jac_cfg_regs.sv */
// calibration and deadzone registers with a plain write port
// depends on jac_pkg
`timescale 1ns / 1ps

module jac_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jac_pkg::CAL_W-1:0]      cfg_data_i,
  output jac_pkg::jac_cfg_t              cfg_o
);
  import jac_pkg::*;

  jac_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_x_cal  <= CAL_RESET;
      cfg_q.left_y_cal  <= CAL_RESET;
      cfg_q.right_x_cal <= CAL_RESET;
      cfg_q.right_y_cal <= CAL_RESET;
      cfg_q.left_dz     <= DZ_RESET;
      cfg_q.right_dz    <= DZ_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT_X_CAL:  cfg_q.left_x_cal  <= cfg_data_i;
        REG_LEFT_Y_CAL:  cfg_q.left_y_cal  <= cfg_data_i;
        REG_RIGHT_X_CAL: cfg_q.right_x_cal <= cfg_data_i;
        REG_RIGHT_Y_CAL: cfg_q.right_y_cal <= cfg_data_i;
        REG_LEFT_DZ:     cfg_q.left_dz     <= cfg_data_i[DZ_W-1:0];
        REG_RIGHT_DZ:    cfg_q.right_dz    <= cfg_data_i[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/jac_axis_prep.sv */
// per-axis front end: center offset, magnitude, span pick, deadzone and saturation flags
// depends on jac_pkg
`timescale 1ns / 1ps

module jac_axis_prep (
  input  logic [jac_pkg::MAG_W-1:0] raw_i,
  input  logic [jac_pkg::CAL_W-1:0] cal_i,
  input  logic [jac_pkg::DZ_W-1:0]  dz_i,
  output jac_pkg::jac_axis_t        axis_o
);
  import jac_pkg::*;

  logic [MAG_W-1:0] center, above, below, mag, span;
  logic [MAG_W:0]   diff, diff_neg;
  logic             neg;

  always_comb begin
    center   = cal_i[MAG_W-1:0];
    above    = cal_i[2*MAG_W-1:MAG_W];
    below    = cal_i[3*MAG_W-1:2*MAG_W];
    diff     = {1'b0, raw_i} - {1'b0, center};
    diff_neg = '0 - diff;
    neg      = diff[MAG_W];
    mag      = neg ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    span     = neg ? below : above;

    axis_o.neg  = neg;
    axis_o.mag  = mag;
    axis_o.span = span;
    axis_o.zero = (mag < dz_i) || (mag == '0);
    axis_o.sat  = (span == '0) || (mag >= span);
  end

endmodule

/* hw/rtl/jac_div_step.sv */
// STEP bits of restoring division, remainder kept below the divisor
// depends on jac_pkg
`timescale 1ns / 1ps

module jac_div_step #(
  parameter int unsigned DW   = 15,
  parameter int unsigned STEP = 3
) (
  input  logic [jac_pkg::MAG_W-1:0] rem_i,
  input  logic [DW-1:0]             dq_i,
  input  logic [jac_pkg::MAG_W-1:0] span_i,
  output logic [jac_pkg::MAG_W-1:0] rem_o,
  output logic [DW-1:0]             dq_o
);
  import jac_pkg::*;

  logic [MAG_W-1:0] rem;
  logic [DW-1:0]    dq;
  logic [MAG_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    rem = rem_i;
    dq  = dq_i;
    for (int unsigned k = 0; k < STEP; k++) begin
      trial = {rem, dq[DW-1]};
      diff  = trial - {1'b0, span_i};
      ge    = trial >= {1'b0, span_i};
      rem   = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      dq    = {dq[DW-2:0], ge};
    end
    rem_o = rem;
    dq_o  = dq;
  end

endmodule

/* hw/rtl/joystick_axis_calibrator_core.sv */
// throughput: one sample per cycle; stages: unpack/flags, multiply, 3-bit divider slices, output
// each stage holds its word under back-pressure and fills bubbles upstream of a stall
// reset: async active low, clears all stage valid bits and loads the calibration defaults
// depends on jac_pkg, jac_stream_if, jac_cfg_regs, jac_axis_prep, jac_div_step
`timescale 1ns / 1ps

module joystick_axis_calibrator_core #(
  parameter int unsigned FULL_SCALE = 32767
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  jac_stream_if.sink                    in_i,
  jac_stream_if.source                  out_o,
  input  logic                          cfg_we_i,
  input  logic [jac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [jac_pkg::CAL_W-1:0]     cfg_data_i
);
  import jac_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned QW       = $clog2(FULL_SCALE + 1);
  localparam int unsigned DIV_STEP = 3;
  localparam int unsigned NDIV     = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DW       = NDIV * DIV_STEP;
  localparam int unsigned NS       = NDIV + 3;
  localparam logic [QW-1:0] FS_Q = QW'(FULL_SCALE);
  localparam logic signed [OUT_W-1:0] FS_POS = OUT_W'(FULL_SCALE);
  localparam logic signed [OUT_W-1:0] FS_NEG = -FS_POS;

  typedef struct packed {
    logic             neg;
    logic             zero;
    logic             sat;
    logic [MAG_W-1:0] span;
    logic [MAG_W-1:0] rem;
    logic [DW-1:0]    dq;
  } div_axis_t;

  typedef struct packed {
    logic      side;
    div_axis_t x;
    div_axis_t y;
  } div_t;

  // stage valids and advance chain
  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = out_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_i.ready = adv[0];

  // configuration
  jac_cfg_t cfg;

  jac_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // stage 0: unpack and flags
  jac_in_t          in_w;
  logic [MAG_W-1:0] raw_x, raw_y;
  logic [CAL_W-1:0] cal_x, cal_y;
  logic [DZ_W-1:0]  dz;
  jac_prep_t        s0_d, s0_q;

  always_comb begin
    in_w  = in_i.data;
    raw_x = {in_w.mid_byte[3:0], in_w.low_byte};
    raw_y = {in_w.high_byte, in_w.mid_byte[7:4]};
    cal_x = in_w.side ? cfg.left_x_cal : cfg.right_x_cal;
    cal_y = in_w.side ? cfg.left_y_cal : cfg.right_y_cal;
    dz    = in_w.side ? cfg.left_dz : cfg.right_dz;
  end

  jac_axis_prep u_prep_x (.raw_i(raw_x), .cal_i(cal_x), .dz_i(dz), .axis_o(s0_d.x));
  jac_axis_prep u_prep_y (.raw_i(raw_y), .cal_i(cal_y), .dz_i(dz), .axis_o(s0_d.y));
  assign s0_d.side = in_w.side;

  always_ff @(posedge clk_i) begin
    if (adv[0]) s0_q <= s0_d;
  end

  // stage 1: scale by full scale
  logic [MAG_W+QW-1:0] prod_x, prod_y;
  logic [MAG_W+DW-1:0] dvd_x, dvd_y;
  div_t                mul_d, mul_q;

  always_comb begin
    prod_x = s0_q.x.mag * FS_Q;
    prod_y = s0_q.y.mag * FS_Q;
    dvd_x  = (MAG_W+DW)'(prod_x);
    dvd_y  = (MAG_W+DW)'(prod_y);

    mul_d.side   = s0_q.side;
    mul_d.x.neg  = s0_q.x.neg;
    mul_d.x.zero = s0_q.x.zero;
    mul_d.x.sat  = s0_q.x.sat;
    mul_d.x.span = s0_q.x.span;
    mul_d.x.rem  = dvd_x[MAG_W+DW-1:DW];
    mul_d.x.dq   = dvd_x[DW-1:0];
    mul_d.y.neg  = s0_q.y.neg;
    mul_d.y.zero = s0_q.y.zero;
    mul_d.y.sat  = s0_q.y.sat;
    mul_d.y.span = s0_q.y.span;
    mul_d.y.rem  = dvd_y[MAG_W+DW-1:DW];
    mul_d.y.dq   = dvd_y[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) mul_q <= mul_d;
  end

  // divider slices
  div_t div_w [NDIV+1];
  assign div_w[0] = mul_q;

  for (genvar i = 1; i <= NDIV; i++) begin : g_div
    div_t nx, stg_q;

    jac_div_step #(.DW(DW), .STEP(DIV_STEP)) u_step_x (
      .rem_i  (div_w[i-1].x.rem),
      .dq_i   (div_w[i-1].x.dq),
      .span_i (div_w[i-1].x.span),
      .rem_o  (nx.x.rem),
      .dq_o   (nx.x.dq)
    );

    jac_div_step #(.DW(DW), .STEP(DIV_STEP)) u_step_y (
      .rem_i  (div_w[i-1].y.rem),
      .dq_i   (div_w[i-1].y.dq),
      .span_i (div_w[i-1].y.span),
      .rem_o  (nx.y.rem),
      .dq_o   (nx.y.dq)
    );

    assign nx.side   = div_w[i-1].side;
    assign nx.x.neg  = div_w[i-1].x.neg;
    assign nx.x.zero = div_w[i-1].x.zero;
    assign nx.x.sat  = div_w[i-1].x.sat;
    assign nx.x.span = div_w[i-1].x.span;
    assign nx.y.neg  = div_w[i-1].y.neg;
    assign nx.y.zero = div_w[i-1].y.zero;
    assign nx.y.sat  = div_w[i-1].y.sat;
    assign nx.y.span = div_w[i-1].y.span;

    always_ff @(posedge clk_i) begin
      if (adv[i+1]) stg_q <= nx;
    end

    assign div_w[i] = stg_q;
  end

  // output stage: flags, sign and result register
  function automatic logic signed [OUT_W-1:0] axis_value(div_axis_t a);
    logic signed [OUT_W-1:0] mag;
    if (a.zero) begin
      mag = '0;
    end else if (a.sat) begin
      mag = FS_POS;
    end else begin
      mag = OUT_W'(a.dq[QW-1:0]);
    end
    return a.neg ? -mag : mag;
  endfunction

  jac_out_t out_d, out_q;

  always_comb begin
    out_d.side_out = div_w[NDIV].side;
    out_d.x_value  = axis_value(div_w[NDIV].x);
    out_d.y_value  = axis_value(div_w[NDIV].y);
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) out_q <= out_d;
  end

  assign out_o.valid = v_q[NS-1];
  assign out_o.data  = out_q;

  `JAC_ASSERT(a_out_range, out_o.valid |-> (out_o.data.x_value <= FS_POS) && (out_o.data.x_value >= FS_NEG) && (out_o.data.y_value <= FS_POS) && (out_o.data.y_value >= FS_NEG), "result beyond full scale")
  `JAC_ASSERT_ALWAYS(a_ready_follows, out_o.ready |-> in_i.ready, "input stalled while output drains")
  `JAC_ASSERT(a_mul_hold, v_q[1] && !adv[2] |=> v_q[1] && $stable(mul_q), "multiply stage lost its word")
  `JAC_ASSERT(a_zero_out, v_q[NS-2] && adv[NS-1] && div_w[NDIV].x.zero |=> out_o.data.x_value == '0, "deadzone word not zero")

endmodule

/* tb/joystick_axis_calibrator_core_tb.sv */
// self-checking testbench for joystick_axis_calibrator_core: directed samples, then random
// samples over many calibration settings, checked against typed row values or an in-bench calibration model
// depends on jac_pkg, jac_stream_if and the calibrator rtl
`timescale 1ns / 1ps

module joystick_axis_calibrator_core_tb;
  import jac_pkg::*;

  localparam int FULL_SCALE  = 32767;
  localparam int CYCLE_LIMIT = 300000;
  localparam int BLOCKS      = 12;
  localparam int BLOCK_WORDS = 142;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 20;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [CAL_W-1:0] CAL_ZERO_SPAN = 36'h000000800;
  localparam logic [CAL_W-1:0] CAL_ALL_ONES  = 36'hfffffffff;
  localparam logic [CAL_W-1:0] CAL_LOW_EDGE  = 36'h000fff000;
  localparam logic [CAL_W-1:0] CAL_ALL_ZERO  = 36'h000000000;

  typedef struct {
    bit side;
    int raw_x;
    int raw_y;
    int setting;
    bit typed;
    int want_x;
    int want_y;
  } sample_row_t;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CAL_W-1:0]     cfg_data_i;

  jac_stream_if #(.T(jac_in_t))  in_ch ();
  jac_stream_if #(.T(jac_out_t)) out_ch ();

  joystick_axis_calibrator_core #(
    .FULL_SCALE(FULL_SCALE)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  jac_cfg_t cal_model = '{CAL_RESET, CAL_RESET, CAL_RESET, CAL_RESET, DZ_RESET, DZ_RESET};
  jac_out_t pending_axes[$];
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_req;

  // setting 0 is the reset state and is never written
  jac_cfg_t dir_settings [4] = '{
    '{CAL_RESET, CAL_RESET, CAL_RESET, CAL_RESET, DZ_RESET, DZ_RESET},
    '{CAL_ZERO_SPAN, CAL_ZERO_SPAN, CAL_ZERO_SPAN, CAL_ZERO_SPAN, 12'd4095, 12'd0},
    '{CAL_ALL_ONES, CAL_ALL_ONES, CAL_ALL_ONES, CAL_ALL_ONES, 12'd0, 12'd1},
    '{CAL_LOW_EDGE, CAL_LOW_EDGE, CAL_LOW_EDGE, CAL_LOW_EDGE, 12'd2, 12'd4095}
  };

  sample_row_t dir_rows [18] = '{
    '{1'b1, 2048, 2048, 0, 1'b1, 0, 0},
    '{1'b0, 0, 4095, 0, 1'b1, -32767, 32767},
    '{1'b1, 4095, 0, 0, 1'b1, 32767, -32767},
    '{1'b0, 2560, 1536, 0, 1'b0, 0, 0},
    '{1'b1, 3072, 1024, 0, 1'b1, 32767, -32767},
    '{1'b0, 2049, 2047, 0, 1'b0, 0, 0},
    '{1'b1, 3071, 1025, 0, 1'b0, 0, 0},
    '{1'b0, 2049, 2047, 1, 1'b1, 32767, -32767},
    '{1'b0, 2048, 2048, 1, 1'b1, 0, 0},
    '{1'b1, 4095, 0, 1, 1'b1, 0, 0},
    '{1'b1, 2048, 2048, 1, 1'b1, 0, 0},
    '{1'b1, 0, 4095, 2, 1'b1, -32767, 0},
    '{1'b1, 4094, 4094, 2, 1'b0, 0, 0},
    '{1'b0, 4094, 0, 2, 1'b0, 0, 0},
    '{1'b1, 4095, 0, 3, 1'b1, 32767, 0},
    '{1'b1, 1, 2, 3, 1'b0, 0, 0},
    '{1'b0, 4095, 4095, 3, 1'b0, 0, 0},
    '{1'b0, 4094, 1, 3, 1'b0, 0, 0}
  };

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic signed [OUT_W-1:0] scale_axis(logic [11:0] raw, logic [CAL_W-1:0] cal,
                                                          logic [DZ_W-1:0] dz);
    int d;
    int mag;
    int span;
    int q;
    d   = int'(raw) - int'(cal[11:0]);
    mag = (d < 0) ? -d : d;
    if (mag < int'(dz) || d == 0) return '0;
    span = (d > 0) ? int'(cal[23:12]) : int'(cal[35:24]);
    if (span == 0 || mag >= span) begin
      q = FULL_SCALE;
    end else begin
      q = (mag * FULL_SCALE) / span;
      if (q > FULL_SCALE) q = FULL_SCALE;
    end
    return (d > 0) ? OUT_W'(q) : OUT_W'(-q);
  endfunction

  function automatic jac_out_t calibrate_word(jac_in_t w);
    jac_out_t r;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    raw_x = {w.mid_byte[3:0], w.low_byte};
    raw_y = {w.high_byte, w.mid_byte[7:4]};
    r.side_out = w.side;
    if (w.side) begin
      r.x_value = scale_axis(raw_x, cal_model.left_x_cal, cal_model.left_dz);
      r.y_value = scale_axis(raw_y, cal_model.left_y_cal, cal_model.left_dz);
    end else begin
      r.x_value = scale_axis(raw_x, cal_model.right_x_cal, cal_model.right_dz);
      r.y_value = scale_axis(raw_y, cal_model.right_y_cal, cal_model.right_dz);
    end
    return r;
  endfunction

  function automatic jac_in_t pack_word(bit side, logic [11:0] x, logic [11:0] y);
    jac_in_t w;
    w.side      = side;
    w.low_byte  = x[7:0];
    w.mid_byte  = {y[3:0], x[11:8]};
    w.high_byte = y[11:4];
    return w;
  endfunction

  function automatic void update_cal_model(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
    case (idx)
      REG_LEFT_X_CAL:  cal_model.left_x_cal  = val;
      REG_LEFT_Y_CAL:  cal_model.left_y_cal  = val;
      REG_RIGHT_X_CAL: cal_model.right_x_cal = val;
      REG_RIGHT_Y_CAL: cal_model.right_y_cal = val;
      REG_LEFT_DZ:     cal_model.left_dz     = val[DZ_W-1:0];
      REG_RIGHT_DZ:    cal_model.right_dz    = val[DZ_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [11:0] pick_field();
    case ($urandom_range(4))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'($urandom_range(1, 64));
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  function automatic jac_cfg_t pick_setting();
    jac_cfg_t s;
    s.left_x_cal  = {pick_field(), pick_field(), 12'($urandom_range(4095))};
    s.left_y_cal  = {pick_field(), pick_field(), 12'($urandom_range(4095))};
    s.right_x_cal = {pick_field(), pick_field(), 12'($urandom_range(4095))};
    s.right_y_cal = {pick_field(), pick_field(), 12'($urandom_range(4095))};
    s.left_dz     = ($urandom_range(3) == 0) ? pick_field() : 12'($urandom_range(40));
    s.right_dz    = ($urandom_range(3) == 0) ? pick_field() : 12'($urandom_range(40));
    return s;
  endfunction

  // raw axis value aimed at the center, deadzone edge and span edges, or drawn anywhere in range
  function automatic logic [11:0] pick_raw(logic [CAL_W-1:0] cal, logic [DZ_W-1:0] dz);
    int c;
    int v;
    c = int'(cal[11:0]);
    case ($urandom_range(5))
      1: v = c + int'($urandom_range(2 * int'(dz) + 4)) - int'(dz) - 2;
      2: v = c + int'(cal[23:12]) + int'($urandom_range(4)) - 2;
      3: v = c - int'(cal[35:24]) + int'($urandom_range(4)) - 2;
      4: v = c + int'($urandom_range(6)) - 3;
      default: v = int'($urandom_range(4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    $display("mismatch %s: got %0d, want %0d", what, got, want);
  endtask

  // entered and left at a falling edge
  task automatic send_word(input jac_in_t w, input bit typed, input jac_out_t typed_val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_axes.push_back(typed ? typed_val : calibrate_word(w));
    @(negedge clk_i);
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (pending_axes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    update_cal_model(idx, val);
    @(negedge clk_i);
  endtask

  task automatic load_setting(input jac_cfg_t s);
    logic [CAL_W-1:0] wide;
    write_reg(REG_LEFT_X_CAL, s.left_x_cal);
    write_reg(REG_LEFT_Y_CAL, s.left_y_cal);
    write_reg(REG_RIGHT_X_CAL, s.right_x_cal);
    write_reg(REG_RIGHT_Y_CAL, s.right_y_cal);
    // deadzones get junk above bit 11
    wide = CAL_W'({$urandom, $urandom});
    wide[DZ_W-1:0] = s.left_dz;
    write_reg(REG_LEFT_DZ, wide);
    wide = CAL_W'({$urandom, $urandom});
    wide[DZ_W-1:0] = s.right_dz;
    write_reg(REG_RIGHT_DZ, wide);
    write_reg(REG_SPARE_LO, CAL_W'({$urandom, $urandom}));
    write_reg(REG_SPARE_HI, CAL_W'({$urandom, $urandom}));
    cfg_we_i <= 1'b0;
  endtask

  // result side
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    jac_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_axes.size() == 0) begin
        report_mismatch("unexpected word, side", int'(out_ch.data.side_out), -1);
      end else begin
        want = pending_axes.pop_front();
        if (out_ch.data.side_out !== want.side_out)
          report_mismatch("side_out", int'(out_ch.data.side_out), int'(want.side_out));
        if (out_ch.data.x_value !== want.x_value)
          report_mismatch("x_value", int'(out_ch.data.x_value), int'(want.x_value));
        if (out_ch.data.y_value !== want.y_value)
          report_mismatch("y_value", int'(out_ch.data.y_value), int'(want.y_value));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("joystick_axis_calibrator_core_tb failed");
      $finish;
    end
  end

  initial begin
    jac_in_t     w;
    jac_out_t    typed_val;
    jac_cfg_t    s;
    sample_row_t row;
    int          cur_setting;
    bit          side;
    logic [11:0] x;
    logic [11:0] y;

    hold_req      = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 57;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    cur_setting = 0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.setting != cur_setting) begin
        drain_pipe();
        load_setting(dir_settings[row.setting]);
        cur_setting = row.setting;
      end
      typed_val.side_out = row.side;
      typed_val.x_value  = OUT_W'(row.want_x);
      typed_val.y_value  = OUT_W'(row.want_y);
      send_word(pack_word(row.side, 12'(row.raw_x), 12'(row.raw_y)), row.typed, typed_val);
    end

    for (int blk = 0; blk < BLOCKS; blk++) begin
      drain_pipe();
      case (blk / 4)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (blk == 1)
        s = '{CAL_ALL_ZERO, CAL_ALL_ZERO, CAL_ALL_ZERO, CAL_ALL_ZERO, 12'd0, 12'd0};
      else if (blk == 5)
        s = '{CAL_ALL_ONES, CAL_ALL_ONES, CAL_ALL_ONES, CAL_ALL_ONES, 12'd4095, 12'd0};
      else
        s = pick_setting();
      load_setting(s);
      // stall the result side long enough to back up the input
      if (blk == 8) hold_req = 1'b1;
      for (int n = 0; n < BLOCK_WORDS; n++) begin
        side = 1'($urandom_range(1));
        if (side) begin
          x = pick_raw(cal_model.left_x_cal, cal_model.left_dz);
          y = pick_raw(cal_model.left_y_cal, cal_model.left_dz);
        end else begin
          x = pick_raw(cal_model.right_x_cal, cal_model.right_dz);
          y = pick_raw(cal_model.right_y_cal, cal_model.right_dz);
        end
        w = pack_word(side, x, y);
        send_word(w, 1'b0, typed_val);
      end
    end

    drain_pipe();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_axes.size() == 0) begin
      $display("joystick_axis_calibrator_core_tb passed");
    end else begin
      $display("joystick_axis_calibrator_core_tb failed");
    end
    $finish;
  end

endmodule
